// ===== rtl/core/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg: shared types and constants of the packed pattern unpacker
// Holds the result beat layout, parse phase codes and register indexes.
// ----------------------------------------------------------------------------
package ppu_pkg;

  // One result beat: a decoded cell or an end of pattern report.
  typedef struct packed {
    logic       kind;
    logic [15:0] row_index;
    logic [4:0] channel_index;
    logic [7:0] note_value;
    logic [7:0] instrument_number;
    logic       note_present;
    logic [7:0] volume_value;
    logic       volume_present;
    logic [7:0] effect_code;
    logic [7:0] effect_param;
    logic [3:0] warning_bits;
    logic       cell_dropped;
  } result_t;

  localparam logic KIND_CELL   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Parse phases, one-hot.
  typedef enum logic [10:0] {
    PH_LEN0   = 11'b000_0000_0001,
    PH_LEN1   = 11'b000_0000_0010,
    PH_ROWS0  = 11'b000_0000_0100,
    PH_ROWS1  = 11'b000_0000_1000,
    PH_STATUS = 11'b000_0001_0000,
    PH_NOTE   = 11'b000_0010_0000,
    PH_INSTR  = 11'b000_0100_0000,
    PH_E1C    = 11'b000_1000_0000,
    PH_E1D    = 11'b001_0000_0000,
    PH_E2C    = 11'b010_0000_0000,
    PH_E2D    = 11'b100_0000_0000
  } phase_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_IGNORE_MASK = 2'd0;
  localparam logic [1:0] REG_NOTE_OFF    = 2'd1;
  localparam logic [1:0] REG_NOTE_NONE   = 2'd2;
  localparam logic [1:0] REG_LAST_NOTE   = 2'd3;

  // Stream byte codes and effect numbers.
  localparam logic [7:0] NOTE_OFF_BYTE  = 8'd160;
  localparam logic [7:0] NOTE_NONE_BYTE = 8'd255;
  localparam logic [7:0] FX_VOLUME      = 8'h0c;
  localparam logic [7:0] FX_PANNING     = 8'h0a;
  localparam logic [7:0] FX_LAST_LETTER = 8'h23;
  localparam logic [7:0] FX_LAST_DIGIT  = 8'h09;
  localparam logic [7:0] VOLUME_MAX     = 8'h40;
  localparam logic [7:0] PAN_BASE       = 8'd128;
  localparam logic [16:0] COUNT_MAX     = 17'h1ffff;

  localparam int WARN_ODD_NOTE = 0;
  localparam int WARN_STRAY_FX = 1;
  localparam int WARN_LOST_FX  = 2;
  localparam int WARN_LENGTH   = 3;

endpackage

// ===== rtl/core/ppu_byte_if.sv =====
// ----------------------------------------------------------------------------
// ppu_byte_if: input byte channel
// Valid/ready channel that carries one stream byte per beat.
// ----------------------------------------------------------------------------
interface ppu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/ppu_result_if.sv =====
// ----------------------------------------------------------------------------
// ppu_result_if: result channel
// Valid/ready channel that carries one decoded cell or report per beat.
// ----------------------------------------------------------------------------
interface ppu_result_if;
  logic            valid;
  logic            ready;
  ppu_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/packed_pattern_unpacker_core.sv =====
// ----------------------------------------------------------------------------
// packed_pattern_unpacker_core: packed pattern stream decoder
// Parses a packed pattern byte stream into cells and end of pattern reports.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle, sustained, while results are taken.
// Output: the result beat for the byte that completes it is registered
//   in the output register, or parked in the skid entry while the output
//   register is held; behind the parse state these are the only stages.
// Reset: synchronous, active high; the parser expects a first length byte,
//   all counters clear, registers take their documented defaults.
module packed_pattern_unpacker_core #(
  parameter int CHANNEL_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst,
  ppu_byte_if.sink           stream,
  ppu_result_if.source       cells,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int MASK_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers. Only the channels that exist get a mask bit.
  // --------------------------------------------------------------------------
  logic [CHANNEL_COUNT-1:0] ignore_mask;
  logic [7:0]               note_off_code;
  logic [7:0]               note_none_code;
  logic [7:0]               last_valid_note;
  logic                     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_mask     <= '0;
      note_off_code   <= 8'd255;
      note_none_code  <= 8'd0;
      last_valid_note <= 8'd120;
    end else if (cfg_write) begin
      case (paddr[3:2])
        ppu_pkg::REG_IGNORE_MASK: ignore_mask     <= pwdata[CHANNEL_COUNT-1:0];
        ppu_pkg::REG_NOTE_OFF:    note_off_code   <= pwdata[7:0];
        ppu_pkg::REG_NOTE_NONE:   note_none_code  <= pwdata[7:0];
        ppu_pkg::REG_LAST_NOTE:   last_valid_note <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ppu_pkg::REG_IGNORE_MASK: prdata = 32'(ignore_mask);
      ppu_pkg::REG_NOTE_OFF:    prdata = {24'd0, note_off_code};
      ppu_pkg::REG_NOTE_NONE:   prdata = {24'd0, note_none_code};
      ppu_pkg::REG_LAST_NOTE:   prdata = {24'd0, last_valid_note};
      default:                  prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Panning fold: floor(d * 64 / 255) + 128. With x = 64*d, floor(x/256) is
  // d[7:2] and the leftover x - 255*floor(x/256) = (x mod 256) + d[7:2]
  // never reaches 510, so a single compare against 255 corrects the quotient.
  // The corrected quotient reaches 64 at full scale, so it needs seven bits.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pan_of(input logic [7:0] d);
    logic [8:0] rem;
    logic [6:0] quo;
    rem = {1'b0, d[1:0], 6'd0} + {3'd0, d[7:2]};
    quo = {1'b0, d[7:2]} + {6'd0, (rem >= 9'd255)};
    return ppu_pkg::PAN_BASE + {1'b0, quo};
  endfunction

  function automatic logic [7:0] vol_of(input logic [7:0] d);
    return (d < ppu_pkg::VOLUME_MAX) ? d : ppu_pkg::VOLUME_MAX;
  endfunction

  // --------------------------------------------------------------------------
  // Parse state.
  // --------------------------------------------------------------------------
  ppu_pkg::phase_t phase, phase_next;
  logic [15:0] pattern_length, pattern_length_next;
  logic [15:0] row_total, row_total_next;
  logic [15:0] row_counter, row_counter_next;
  logic [16:0] bytes_consumed, bytes_consumed_next;
  logic [7:0]  status_held, status_held_next;
  logic [7:0]  note_held, note_held_next;
  logic [7:0]  instrument_held, instrument_held_next;
  logic [7:0]  first_code, first_code_next;
  logic [7:0]  first_data, first_data_next;
  logic [7:0]  second_code, second_code_next;

  logic        in_fire;
  logic [7:0]  b;
  logic [16:0] count_base;
  logic        emit_cell;
  logic        emit_report;

  // Output register plus one skid entry; the input only stalls while the
  // skid entry is full.
  logic              out_valid;
  ppu_pkg::result_t  out_data;
  logic              skid_valid;
  ppu_pkg::result_t  skid_data;
  logic              out_fire;

  assign stream.ready = ~skid_valid;
  assign in_fire      = stream.valid & stream.ready;
  assign out_fire     = out_valid & cells.ready;
  assign b            = stream.data_byte;

  // Next state for every phase. The cell is built from the next values of
  // the held fields, so the byte that finishes a cell takes part directly.
  always_comb begin
    phase_next           = phase;
    pattern_length_next  = pattern_length;
    row_total_next       = row_total;
    row_counter_next     = row_counter;
    status_held_next     = status_held;
    note_held_next       = note_held;
    instrument_held_next = instrument_held;
    first_code_next      = first_code;
    first_data_next      = first_data;
    second_code_next     = second_code;
    emit_cell            = 1'b0;
    emit_report          = 1'b0;

    // The byte count restarts with every new pattern and saturates.
    count_base = (phase == ppu_pkg::PH_LEN0) ? 17'd0 : bytes_consumed;
    bytes_consumed_next = (count_base == ppu_pkg::COUNT_MAX) ? count_base
                                                             : count_base + 17'd1;

    case (phase)
      ppu_pkg::PH_LEN0: begin
        pattern_length_next = {8'd0, b};
        phase_next          = ppu_pkg::PH_LEN1;
      end
      ppu_pkg::PH_LEN1: begin
        pattern_length_next = {b, pattern_length[7:0]};
        phase_next          = ppu_pkg::PH_ROWS0;
      end
      ppu_pkg::PH_ROWS0: begin
        row_total_next = {8'd0, b};
        phase_next     = ppu_pkg::PH_ROWS1;
      end
      ppu_pkg::PH_ROWS1: begin
        row_total_next   = {b, row_total[7:0]};
        row_counter_next = 16'd0;
        if (row_total_next == 16'd0) begin
          emit_report = 1'b1;
          phase_next  = ppu_pkg::PH_LEN0;
        end else begin
          phase_next = ppu_pkg::PH_STATUS;
        end
      end
      ppu_pkg::PH_STATUS: begin
        if (b == 8'd0) begin
          // End of row.
          row_counter_next = row_counter + 16'd1;
          if (row_counter_next == row_total) begin
            emit_report = 1'b1;
            phase_next  = ppu_pkg::PH_LEN0;
          end
        end else begin
          status_held_next     = b;
          note_held_next       = 8'd0;
          instrument_held_next = 8'd0;
          first_code_next      = 8'd0;
          first_data_next      = 8'd0;
          second_code_next     = 8'd0;
          if (b[5]) begin
            phase_next = ppu_pkg::PH_NOTE;
          end else if (b[7:6] != 2'b00) begin
            phase_next = ppu_pkg::PH_E1C;
          end else begin
            emit_cell = 1'b1;
          end
        end
      end
      ppu_pkg::PH_NOTE: begin
        note_held_next = b;
        phase_next     = ppu_pkg::PH_INSTR;
      end
      ppu_pkg::PH_INSTR: begin
        instrument_held_next = b;
        if (status_held[7:6] != 2'b00) begin
          phase_next = ppu_pkg::PH_E1C;
        end else begin
          emit_cell  = 1'b1;
          phase_next = ppu_pkg::PH_STATUS;
        end
      end
      ppu_pkg::PH_E1C: begin
        first_code_next = b;
        phase_next      = ppu_pkg::PH_E1D;
      end
      ppu_pkg::PH_E1D: begin
        first_data_next = b;
        if (status_held[7:6] == 2'b11) begin
          phase_next = ppu_pkg::PH_E2C;
        end else begin
          emit_cell  = 1'b1;
          phase_next = ppu_pkg::PH_STATUS;
        end
      end
      ppu_pkg::PH_E2C: begin
        second_code_next = b;
        phase_next       = ppu_pkg::PH_E2D;
      end
      ppu_pkg::PH_E2D: begin
        emit_cell  = 1'b1;
        phase_next = ppu_pkg::PH_STATUS;
      end
      default: begin
        phase_next = ppu_pkg::PH_LEN0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Cell and report assembly.
  // --------------------------------------------------------------------------
  ppu_pkg::result_t res;
  logic [7:0] eff_raw;
  logic [4:0] ch;

  always_comb begin
    res     = '0;
    eff_raw = 8'd0;
    ch      = status_held_next[4:0];

    if (emit_report) begin
      res.kind      = ppu_pkg::KIND_REPORT;
      res.row_index = row_counter_next;
      res.warning_bits[ppu_pkg::WARN_LENGTH] =
        (bytes_consumed_next != {1'b0, pattern_length_next});
    end else begin
      res.kind          = ppu_pkg::KIND_CELL;
      res.row_index     = row_counter_next;
      res.channel_index = ch;
      res.note_value    = note_none_code;

      // Note and instrument, with the off and none codes remapped.
      if (status_held_next[5]) begin
        res.note_present      = 1'b1;
        res.instrument_number = instrument_held_next;
        if (note_held_next == ppu_pkg::NOTE_OFF_BYTE) begin
          res.note_value = note_off_code;
        end else if (note_held_next == ppu_pkg::NOTE_NONE_BYTE) begin
          res.note_value = note_none_code;
        end else begin
          res.note_value = note_held_next;
          res.warning_bits[ppu_pkg::WARN_ODD_NOTE] =
            (note_held_next == 8'd0) || (note_held_next > last_valid_note);
        end
      end

      // With two effects, a volume effect is folded first, then panning; the
      // other one stays as the effect. If neither folds, the first is lost.
      if (status_held_next[7:6] == 2'b11) begin
        if (first_code_next == ppu_pkg::FX_VOLUME) begin
          res.volume_value   = vol_of(first_data_next);
          res.volume_present = 1'b1;
          eff_raw            = second_code_next;
          res.effect_param   = b;
        end else if (second_code_next == ppu_pkg::FX_VOLUME) begin
          res.volume_value   = vol_of(b);
          res.volume_present = 1'b1;
          eff_raw            = first_code_next;
          res.effect_param   = first_data_next;
        end else if (first_code_next == ppu_pkg::FX_PANNING) begin
          res.volume_value   = pan_of(first_data_next);
          res.volume_present = 1'b1;
          eff_raw            = second_code_next;
          res.effect_param   = b;
        end else if (second_code_next == ppu_pkg::FX_PANNING) begin
          res.volume_value   = pan_of(b);
          res.volume_present = 1'b1;
          eff_raw            = first_code_next;
          res.effect_param   = first_data_next;
        end else begin
          res.warning_bits[ppu_pkg::WARN_LOST_FX] = 1'b1;
          eff_raw          = second_code_next;
          res.effect_param = b;
        end
      end else if (status_held_next[7:6] != 2'b00) begin
        eff_raw          = first_code_next;
        res.effect_param = first_data_next;
      end

      // Effect numbers become digits or letters; anything past the letter
      // range passes through and is flagged as a stray effect.
      if (eff_raw >= 8'd1 && eff_raw <= ppu_pkg::FX_LAST_DIGIT) begin
        res.effect_code = eff_raw + 8'h30;
      end else if (eff_raw >= ppu_pkg::FX_PANNING && eff_raw <= ppu_pkg::FX_LAST_LETTER) begin
        res.effect_code = eff_raw + 8'h40;
      end else begin
        res.effect_code = eff_raw;
        res.warning_bits[ppu_pkg::WARN_STRAY_FX] = (eff_raw != 8'd0);
      end

      // Channels past the configured count are always dropped.
      if (32'(ch) >= 32'(CHANNEL_COUNT)) begin
        res.cell_dropped = 1'b1;
      end else begin
        res.cell_dropped = ignore_mask[ch[MASK_IDX_W-1:0]];
      end
    end
  end

  // --------------------------------------------------------------------------
  // State registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ppu_pkg::PH_LEN0;
      pattern_length  <= 16'd0;
      row_total       <= 16'd0;
      row_counter     <= 16'd0;
      bytes_consumed  <= 17'd0;
      status_held     <= 8'd0;
      note_held       <= 8'd0;
      instrument_held <= 8'd0;
      first_code      <= 8'd0;
      first_data      <= 8'd0;
      second_code     <= 8'd0;
    end else if (in_fire) begin
      phase           <= phase_next;
      pattern_length  <= pattern_length_next;
      row_total       <= row_total_next;
      row_counter     <= row_counter_next;
      bytes_consumed  <= bytes_consumed_next;
      status_held     <= status_held_next;
      note_held       <= note_held_next;
      instrument_held <= instrument_held_next;
      first_code      <= first_code_next;
      first_data      <= first_data_next;
      second_code     <= second_code_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register and skid entry. A new result goes straight to the
  // output register when it is free or being emptied, otherwise it parks in
  // the skid entry, which then stalls the input until it drains.
  // --------------------------------------------------------------------------
  logic res_valid;
  assign res_valid = in_fire & (emit_cell | emit_report);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  assign cells.valid = out_valid;
  assign cells.data  = out_data;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  a_skid_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid && !out_fire) |=> (skid_valid && !stream.ready))
    else $error("result not parked when output stalled");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == ppu_pkg::KIND_REPORT) |->
      (out_data.channel_index == 5'd0 && out_data.note_value == 8'd0 &&
       out_data.effect_code == 8'd0 && out_data.cell_dropped == 1'b0 &&
       out_data.warning_bits[2:0] == 3'd0))
    else $error("report carries cell fields");

  a_report_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && emit_report) |=> (phase == ppu_pkg::PH_LEN0))
    else $error("parser did not restart after report");

  a_volume_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.volume_present) |->
      (out_data.volume_value <= 8'd64 ||
       (out_data.volume_value >= 8'd128 && out_data.volume_value <= 8'd192)))
    else $error("folded volume out of range");

endmodule

// ===== tb/sv/ppu_cell_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_cell_checker: result checker of the packed pattern unpacker
// Watches the byte channel, the result channel and register writes, keeps a
// model of the parser and compares every result beat field by field.
// ----------------------------------------------------------------------------
module ppu_cell_checker #(
  parameter int CHANNEL_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  ppu_byte_if         stream,
  ppu_result_if       cells,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          cells_seen,
  output int          reports_seen
);

  localparam logic [7:0] FLAG_NOTE       = 8'h20;
  localparam logic [7:0] FLAG_FX         = 8'hc0;
  localparam logic [7:0] FX_FIRST_DIGIT  = 8'h01;
  localparam logic [7:0] FX_FIRST_LETTER = 8'h0a;
  localparam logic [7:0] DIGIT_OFFSET    = 8'h30;
  localparam logic [7:0] LETTER_OFFSET   = 8'h40;
  localparam int         PAN_STEPS       = 64;
  localparam int         PAN_FULL_SCALE  = 255;

  // Register shadows.
  logic [31:0] ignore_mask;
  logic [7:0]  off_code;
  logic [7:0]  none_code;
  logic [7:0]  highest_note;

  // Parser shadow.
  ppu_pkg::phase_t expect_phase;
  logic [15:0] declared_len;
  logic [15:0] rows_in_pattern;
  logic [15:0] row_num;
  logic [16:0] byte_count;
  logic [7:0]  status_b;
  logic [7:0]  note_b;
  logic [7:0]  inst_b;
  logic [7:0]  fx1_code;
  logic [7:0]  fx1_data;
  logic [7:0]  fx2_code;

  ppu_pkg::result_t beats_ahead[$];

  function automatic logic [7:0] clamp_volume(input logic [7:0] d);
    return (d < ppu_pkg::VOLUME_MAX) ? d : ppu_pkg::VOLUME_MAX;
  endfunction

  function automatic logic [7:0] pan_column(input logic [7:0] d);
    return 8'((int'(d) * PAN_STEPS) / PAN_FULL_SCALE) + ppu_pkg::PAN_BASE;
  endfunction

  function automatic void emit_report();
    ppu_pkg::result_t beat;
    beat = '0;
    beat.kind = ppu_pkg::KIND_REPORT;
    beat.row_index = row_num;
    beat.warning_bits[ppu_pkg::WARN_LENGTH] = (byte_count != {1'b0, declared_len});
    beats_ahead.push_back(beat);
    expect_phase = ppu_pkg::PH_LEN0;
  endfunction

  function automatic void emit_cell(input logic [7:0] fx2_data);
    ppu_pkg::result_t beat;
    logic [7:0] fx;
    logic [7:0] prm;
    beat = '0;
    fx = 8'd0;
    prm = 8'd0;
    beat.kind = ppu_pkg::KIND_CELL;
    beat.row_index = row_num;
    beat.channel_index = status_b[4:0];
    beat.note_value = none_code;
    if ((status_b & FLAG_NOTE) != 8'd0) begin
      beat.note_present = 1'b1;
      beat.instrument_number = inst_b;
      if (note_b == ppu_pkg::NOTE_OFF_BYTE) begin
        beat.note_value = off_code;
      end else if (note_b == ppu_pkg::NOTE_NONE_BYTE) begin
        beat.note_value = none_code;
      end else begin
        beat.note_value = note_b;
        beat.warning_bits[ppu_pkg::WARN_ODD_NOTE] =
          (note_b == 8'd0) || (note_b > highest_note);
      end
    end
    // With two effects, a volume effect wins the volume column over panning;
    // the first effect is checked before the second one for each kind.
    if ((status_b & FLAG_FX) == FLAG_FX) begin
      beat.volume_present = 1'b1;
      if (fx1_code == ppu_pkg::FX_VOLUME) begin
        beat.volume_value = clamp_volume(fx1_data);
        fx = fx2_code;
        prm = fx2_data;
      end else if (fx2_code == ppu_pkg::FX_VOLUME) begin
        beat.volume_value = clamp_volume(fx2_data);
        fx = fx1_code;
        prm = fx1_data;
      end else if (fx1_code == ppu_pkg::FX_PANNING) begin
        beat.volume_value = pan_column(fx1_data);
        fx = fx2_code;
        prm = fx2_data;
      end else if (fx2_code == ppu_pkg::FX_PANNING) begin
        beat.volume_value = pan_column(fx2_data);
        fx = fx1_code;
        prm = fx1_data;
      end else begin
        beat.volume_present = 1'b0;
        beat.warning_bits[ppu_pkg::WARN_LOST_FX] = 1'b1;
        fx = fx2_code;
        prm = fx2_data;
      end
    end else if ((status_b & FLAG_FX) != 8'd0) begin
      fx = fx1_code;
      prm = fx1_data;
    end
    if (fx >= FX_FIRST_DIGIT && fx <= ppu_pkg::FX_LAST_DIGIT) begin
      fx = fx + DIGIT_OFFSET;
    end else if (fx >= FX_FIRST_LETTER && fx <= ppu_pkg::FX_LAST_LETTER) begin
      fx = fx + LETTER_OFFSET;
    end else if (fx != 8'd0) begin
      beat.warning_bits[ppu_pkg::WARN_STRAY_FX] = 1'b1;
    end
    beat.effect_code = fx;
    beat.effect_param = prm;
    beat.cell_dropped = (int'(status_b[4:0]) >= CHANNEL_COUNT) ? 1'b1
                                                              : ignore_mask[status_b[4:0]];
    beats_ahead.push_back(beat);
    expect_phase = ppu_pkg::PH_STATUS;
  endfunction

  function automatic void close_cell_head();
    if ((status_b & FLAG_FX) != 8'd0) begin
      expect_phase = ppu_pkg::PH_E1C;
    end else begin
      emit_cell(8'd0);
    end
  endfunction

  function automatic void decode_stream_byte(input logic [7:0] b);
    if (expect_phase == ppu_pkg::PH_LEN0) begin
      byte_count = '0;
    end
    if (byte_count != ppu_pkg::COUNT_MAX) begin
      byte_count = byte_count + 17'd1;
    end
    case (expect_phase)
      ppu_pkg::PH_LEN0: begin
        declared_len = {8'd0, b};
        expect_phase = ppu_pkg::PH_LEN1;
      end
      ppu_pkg::PH_LEN1: begin
        declared_len[15:8] = b;
        expect_phase = ppu_pkg::PH_ROWS0;
      end
      ppu_pkg::PH_ROWS0: begin
        rows_in_pattern = {8'd0, b};
        expect_phase = ppu_pkg::PH_ROWS1;
      end
      ppu_pkg::PH_ROWS1: begin
        rows_in_pattern[15:8] = b;
        row_num = '0;
        if (rows_in_pattern == 16'd0) begin
          emit_report();
        end else begin
          expect_phase = ppu_pkg::PH_STATUS;
        end
      end
      ppu_pkg::PH_STATUS: begin
        if (b == 8'd0) begin
          row_num = row_num + 16'd1;
          if (row_num == rows_in_pattern) begin
            emit_report();
          end
        end else begin
          status_b = b;
          note_b = '0;
          inst_b = '0;
          fx1_code = '0;
          fx1_data = '0;
          fx2_code = '0;
          if ((b & FLAG_NOTE) != 8'd0) begin
            expect_phase = ppu_pkg::PH_NOTE;
          end else begin
            close_cell_head();
          end
        end
      end
      ppu_pkg::PH_NOTE: begin
        note_b = b;
        expect_phase = ppu_pkg::PH_INSTR;
      end
      ppu_pkg::PH_INSTR: begin
        inst_b = b;
        close_cell_head();
      end
      ppu_pkg::PH_E1C: begin
        fx1_code = b;
        expect_phase = ppu_pkg::PH_E1D;
      end
      ppu_pkg::PH_E1D: begin
        fx1_data = b;
        if ((status_b & FLAG_FX) == FLAG_FX) begin
          expect_phase = ppu_pkg::PH_E2C;
        end else begin
          emit_cell(8'd0);
        end
      end
      ppu_pkg::PH_E2C: begin
        fx2_code = b;
        expect_phase = ppu_pkg::PH_E2D;
      end
      ppu_pkg::PH_E2D: begin
        emit_cell(b);
      end
      default: begin
        expect_phase = ppu_pkg::PH_LEN0;
      end
    endcase
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    ppu_pkg::result_t want;
    if (rst) begin
      ignore_mask = 32'd0;
      off_code = 8'd255;
      none_code = 8'd0;
      highest_note = 8'd120;
      expect_phase = ppu_pkg::PH_LEN0;
      declared_len = '0;
      rows_in_pattern = '0;
      row_num = '0;
      byte_count = '0;
      status_b = '0;
      note_b = '0;
      inst_b = '0;
      fx1_code = '0;
      fx1_data = '0;
      fx2_code = '0;
      beats_ahead.delete();
      fail_count = 0;
      cells_seen = 0;
      reports_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          ppu_pkg::REG_IGNORE_MASK: ignore_mask = pwdata;
          ppu_pkg::REG_NOTE_OFF:    off_code = pwdata[7:0];
          ppu_pkg::REG_NOTE_NONE:   none_code = pwdata[7:0];
          ppu_pkg::REG_LAST_NOTE:   highest_note = pwdata[7:0];
          default: ;
        endcase
      end
      if (cells.valid === 1'b1 && cells.ready === 1'b1) begin
        if (beats_ahead.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, cells.data);
        end else begin
          want = beats_ahead.pop_front();
          if (want.kind == ppu_pkg::KIND_REPORT) reports_seen++;
          else cells_seen++;
          check_field("kind", 16'(want.kind), 16'(cells.data.kind));
          check_field("row_index", want.row_index, cells.data.row_index);
          check_field("channel_index", 16'(want.channel_index),
                      16'(cells.data.channel_index));
          check_field("note_value", 16'(want.note_value), 16'(cells.data.note_value));
          check_field("instrument_number", 16'(want.instrument_number),
                      16'(cells.data.instrument_number));
          check_field("note_present", 16'(want.note_present),
                      16'(cells.data.note_present));
          check_field("volume_value", 16'(want.volume_value),
                      16'(cells.data.volume_value));
          check_field("volume_present", 16'(want.volume_present),
                      16'(cells.data.volume_present));
          check_field("effect_code", 16'(want.effect_code), 16'(cells.data.effect_code));
          check_field("effect_param", 16'(want.effect_param),
                      16'(cells.data.effect_param));
          check_field("warning_bits", 16'(want.warning_bits),
                      16'(cells.data.warning_bits));
          check_field("cell_dropped", 16'(want.cell_dropped),
                      16'(cells.data.cell_dropped));
        end
      end
      if (stream.valid === 1'b1 && stream.ready === 1'b1) begin
        decode_stream_byte(stream.data_byte);
      end
    end
    pending <= beats_ahead.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream-level test of the packed pattern unpacker core
// Feeds whole packed patterns through the byte channel under changing
// register settings and handshake pressure; a separate checker predicts and
// compares every result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  // The block holds at most an output register and one skid entry, so the
  // DRAIN_CYCLES tail after the last expected beat is plenty for anything in flight.
  localparam int DRAIN_CYCLES     = 4;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int PHASE_BYTES      = 370;
  localparam int LONG_HOLD_CYCLES = 64;

  localparam logic [7:0] FLAG_NOTE = 8'h20;
  localparam logic [7:0] FLAG_FX   = 8'hc0;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int cells_seen;
  int reports_seen;
  int bytes_sent = 0;

  // Handshake profile, changed between phases by the stimulus process.
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;
  logic hold_armed = 1'b0;

  // Bytes waiting to go out, and the body of the pattern being built.
  logic [7:0] stream_bytes[$];
  logic [7:0] pattern_body[$];

  ppu_byte_if   stream_ch();
  ppu_result_if cell_ch();

  always #1 clk = ~clk;

  packed_pattern_unpacker_core #(
    .CHANNEL_COUNT(32)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .cells   (cell_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppu_cell_checker #(
    .CHANNEL_COUNT(32)
  ) cell_watch (
    .clk          (clk),
    .rst          (rst),
    .stream       (stream_ch),
    .cells        (cell_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .cells_seen   (cells_seen),
    .reports_seen (reports_seen)
  );

  // Note bytes lean toward the special codes, zero and fully random bytes,
  // so that note-off, no-note and odd notes all show up often.
  function automatic logic [7:0] pick_note();
    case ($urandom_range(5))
      0: return ppu_pkg::NOTE_OFF_BYTE;
      1: return ppu_pkg::NOTE_NONE_BYTE;
      2: return 8'd0;
      3: return 8'($urandom);
      default: return 8'($urandom_range(1, 120));
    endcase
  endfunction

  // Effect codes cover folding candidates, digits, letters, the empty code
  // and stray codes above the letter range.
  function automatic logic [7:0] pick_fx();
    case ($urandom_range(7))
      0: return ppu_pkg::FX_VOLUME;
      1: return ppu_pkg::FX_PANNING;
      2: return 8'($urandom_range(1, ppu_pkg::FX_LAST_DIGIT));
      3, 4: return 8'($urandom_range(ppu_pkg::FX_LAST_DIGIT + 1, ppu_pkg::FX_LAST_LETTER));
      5: return 8'd0;
      6: return 8'($urandom_range(ppu_pkg::FX_LAST_LETTER + 1, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  // Parameters hit the volume clamp boundary and both ends of the byte.
  function automatic logic [7:0] pick_param();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hff;
      2: return ppu_pkg::VOLUME_MAX - 8'd1 + 8'($urandom_range(2));
      default: return 8'($urandom);
    endcase
  endfunction

  // Appends one cell to the pattern body; the status byte decides which of
  // the note, instrument and effect bytes follow.
  task automatic queue_cell(input logic [7:0] status);
    pattern_body.push_back(status);
    if ((status & FLAG_NOTE) != 8'd0) begin
      pattern_body.push_back(pick_note());
      pattern_body.push_back(8'($urandom));
    end
    if ((status & FLAG_FX) != 8'd0) begin
      pattern_body.push_back(pick_fx());
      pattern_body.push_back(pick_param());
      if ((status & FLAG_FX) == FLAG_FX) begin
        pattern_body.push_back(pick_fx());
        pattern_body.push_back(pick_param());
      end
    end
  endtask

  // Puts the little-endian length and row count in front of the body and
  // moves the whole pattern to the send queue.
  task automatic queue_framed(input logic [15:0] declared, input logic [15:0] rows);
    stream_bytes.push_back(declared[7:0]);
    stream_bytes.push_back(declared[15:8]);
    stream_bytes.push_back(rows[7:0]);
    stream_bytes.push_back(rows[15:8]);
    while (pattern_body.size() > 0) stream_bytes.push_back(pattern_body.pop_front());
  endtask

  // A random but well-formed pattern: a few rows of a few cells each. Most
  // declare their true length; the rest carry a random length and so almost
  // always end in a mismatch report. Zero-row patterns come up regularly.
  task automatic queue_pattern();
    int rows;
    int r;
    logic [15:0] declared;
    rows = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    pattern_body.delete();
    for (r = 0; r < rows; r++) begin
      repeat ($urandom_range(0, 4)) queue_cell(8'($urandom_range(1, 255)));
      pattern_body.push_back(8'h00);
    end
    if ($urandom_range(6) == 0) declared = 16'($urandom);
    else declared = 16'(pattern_body.size() + 4);
    queue_framed(declared, 16'(rows));
  endtask

  // Sends the queued bytes. Valid stays high from one beat to the next when
  // no gap is drawn, and drops only for a gap or once the queue is empty.
  task automatic send_queued();
    logic [7:0] b;
    while (stream_bytes.size() > 0) begin
      b = stream_bytes.pop_front();
      while ($urandom_range(99) < src_idle_pct) begin
        stream_ch.valid <= 1'b0;
        @(posedge clk);
      end
      stream_ch.valid <= 1'b1;
      stream_ch.data_byte <= b;
      @(posedge clk);
      while (stream_ch.ready !== 1'b1) @(posedge clk);
      bytes_sent++;
    end
    stream_ch.valid <= 1'b0;
  endtask

  // First lets the checker see the last accepted byte, then waits until
  // every predicted beat has been taken, then runs the DRAIN_CYCLES tail so
  // that any beat still in flight shows up.
  task automatic wait_until_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle. The select is left high
  // between writes so it never drops and rises within one step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] mask, input logic [7:0] off_code,
                                input logic [7:0] none_code, input logic [7:0] top_note);
    write_reg(ppu_pkg::REG_IGNORE_MASK, mask);
    write_reg(ppu_pkg::REG_NOTE_OFF, {24'd0, off_code});
    write_reg(ppu_pkg::REG_NOTE_NONE, {24'd0, none_code});
    write_reg(ppu_pkg::REG_LAST_NOTE, {24'd0, top_note});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Result side. An ordinary pass through the loop makes one assignment to
  // ready and then waits for the clock. When a long hold is armed, ready is held
  // low for LONG_HOLD_CYCLES while the sender keeps offering bytes, so the result
  // register and skid entry fill and the block has to back-pressure its input.
  initial begin : result_taker
    int held;
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        for (held = 0; held < LONG_HOLD_CYCLES; held++) begin
          cell_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        cell_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Hard stop in case the block hangs or a beat never arrives.
  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("FAIL packed_pattern_unpacker_core");
    $finish;
  end

  initial begin : stimulus
    int phase;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    stream_ch.valid <= 1'b0;
    stream_ch.data_byte <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed patterns at the reset settings. The first has zero rows, so
    // its report follows the fourth header byte. The second declares one
    // byte too few and covers note-off, a clamped volume folded from the
    // first effect, a letter effect, an empty cell on the top channel, and a
    // full-scale panning folded from the second effect next to a digit.
    stream_bytes = '{8'd4, 8'd0, 8'd0, 8'd0,
                     8'd18, 8'd0, 8'd2, 8'd0,
                     FLAG_FX | FLAG_NOTE | 8'd3, ppu_pkg::NOTE_OFF_BYTE, 8'hff,
                     ppu_pkg::FX_VOLUME, 8'h7f, 8'h13, 8'h55,
                     8'h1f, 8'h00,
                     FLAG_FX | 8'd5, 8'h01, 8'h10, ppu_pkg::FX_PANNING, 8'hff, 8'h00};
    send_queued();
    wait_until_drained();

    // Random phases. Registers change only here, with the block idle. The
    // handshake profile moves from a slow receiver to a slow sender and then
    // to full speed, where the long receiver hold is applied.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          apply_settings($urandom, 8'd0, 8'd255, 8'd1);
          src_idle_pct = 37;
          sink_idle_pct = 84;
        end
        1: begin
          apply_settings(32'hffff_ffff, 8'd255, 8'd0, 8'd255);
          src_idle_pct = 84;
          sink_idle_pct = 37;
        end
        default: begin
          apply_settings(32'd0, 8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
          src_idle_pct = 0;
          sink_idle_pct = 0;
          hold_armed = 1'b1;
        end
      endcase
      while (stream_bytes.size() < PHASE_BYTES) queue_pattern();
      send_queued();
      wait_until_drained();
    end

    $display("Run covered %0d stream bytes, giving %0d decoded cells and %0d pattern reports,",
             bytes_sent, cells_seen, reports_seen);
    $display("over four register settings, three handshake profiles and a long receiver hold.");
    if (fail_count == 0) begin
      $display("PASS packed_pattern_unpacker_core");
    end else begin
      $display("FAIL packed_pattern_unpacker_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ppu_pkg.sv
rtl/core/ppu_byte_if.sv
rtl/core/ppu_result_if.sv
rtl/core/packed_pattern_unpacker_core.sv
tb/sv/ppu_cell_checker.sv
tb/sv/tb.sv
